/* sv/dcau_pkg.sv */
// Shared types and constants for the DDR channel address untranslate block.
// No dependencies; every other file in the block imports this package.
package dcau_pkg;

  localparam int ADDR_IN_W  = 40;
  localparam int ADDR_OUT_W = 42;
  localparam int LOW_W      = 7;

  // configuration register indexes
  localparam logic CFG_LAYOUT  = 1'b0;
  localparam logic CFG_CHANNEL = 1'b1;

  localparam logic [7:0] LAYOUT_FOUR = 8'h0F;
  localparam logic [7:0] LAYOUT_TWO  = 8'h0C;
  localparam logic [7:0] ID_UNKNOWN  = 8'hFF;

  // result kinds, also used as the job mode in the queue
  localparam logic [1:0] KIND_RAW      = 2'd0;
  localparam logic [1:0] KIND_POSSIBLE = 2'd1;
  localparam logic [1:0] KIND_MATCHED  = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  // parity masks over address bits 7 and up
  localparam logic [ADDR_IN_W-1:0] ODD_POS_MASK  = 40'hAA_AAAA_AA80;
  localparam logic [ADDR_IN_W-1:0] EVEN_POS_MASK = 40'h55_5555_5500;
  localparam logic [ADDR_IN_W-1:0] HIGH_MASK     = 40'hFF_FFFF_FF80;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [39:0] error_address;
    logic [6:0]  access_type;
    logic [12:0] access_length;
  } in_item_t;

  typedef struct packed {
    logic [41:0] candidate_address;
    logic [1:0]  candidate_index;
    logic [1:0]  hash_channel;
    logic [1:0]  result_kind;
    logic [6:0]  type_out;
    logic [12:0] length_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        four;
    logic [1:0]  idx;
    logic [1:0]  hash;
    logic [39:0] addr;
    logic [6:0]  access_type;
    logic [12:0] access_length;
  } job_t;

endpackage

/* sv/dcau_front.sv */
// Front end: configuration registers, transaction accept and classification.
// Depends on dcau_pkg; feeds one job per accepted transaction into the queue.
module dcau_front import dcau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic     start,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     push,
  output job_t     push_job
);

  logic [7:0] layout_r;
  logic [7:0] chan_r;
  logic       par_odd;
  logic       par_even;
  logic       par_all;
  logic       is_four;
  logic       is_two;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= 8'h00;
      chan_r   <= ID_UNKNOWN;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LAYOUT) begin
        layout_r <= cfg_wdata;
      end else begin
        chan_r <= cfg_wdata;
      end
    end
  end

  // address bit k lands on system bit k+2 (or k+1): the shift keeps the
  // four-channel position parity, so the hash is the address parity xor index
  assign par_odd  = ^(in_item.error_address & ODD_POS_MASK);
  assign par_even = ^(in_item.error_address & EVEN_POS_MASK);
  assign par_all  = ^(in_item.error_address & HIGH_MASK);
  assign is_four  = (layout_r == LAYOUT_FOUR);
  assign is_two   = (layout_r == LAYOUT_TWO);

  assign push = start && !q_full;

  always_comb begin
    push_job               = '0;
    push_job.four          = is_four;
    push_job.addr          = in_item.error_address;
    push_job.access_type   = in_item.access_type;
    push_job.access_length = in_item.access_length;
    if (!is_four && !is_two) begin
      push_job.mode = KIND_RAW;
    end else if (chan_r == ID_UNKNOWN) begin
      push_job.mode = KIND_POSSIBLE;
    end else if (is_four) begin
      if (chan_r[7:2] != 6'd0) begin
        push_job.mode = KIND_NONE;
      end else begin
        push_job.mode = KIND_MATCHED;
        push_job.idx  = {chan_r[1] ^ par_even, chan_r[0] ^ par_odd};
        push_job.hash = chan_r[1:0];
      end
    end else begin
      // two channels: exactly one of the two candidates matches id mod 2
      push_job.mode = KIND_MATCHED;
      push_job.idx  = {1'b0, chan_r[0] ^ par_all};
      push_job.hash = {1'b0, chan_r[0]};
    end
  end

endmodule

/* sv/dcau_queue.sv */
// Short job queue between front and back end.
// Depends on dcau_pkg for the job type and depth.
module dcau_queue import dcau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic empty,
  output logic full,
  output job_t head
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* sv/dcau_back.sv */
// Back end: expands each queued job into its results, one per cycle.
// Depends on dcau_pkg; drives the registered result port.
module dcau_back import dcau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      empty,
  input  job_t      head,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic [1:0]  last_idx;
  logic        is_last;
  logic [1:0]  idx;
  logic [41:0] cand;
  logic        out_valid_r;
  out_item_t   out_item_r;
  out_item_t   out_item_nxt;

  assign last_idx = (head.mode == KIND_POSSIBLE) ? (head.four ? 2'd3 : 2'd1) : 2'd0;
  assign is_last  = (cnt_r == last_idx);
  assign pop      = !empty && is_last;
  assign idx      = (head.mode == KIND_POSSIBLE) ? cnt_r : head.idx;
  assign cnt_nxt  = (empty || is_last) ? 2'd0 : cnt_r + 2'd1;

  always_comb begin
    if (head.four) begin
      cand = {head.addr[39:7], idx, head.addr[6:0]};
    end else begin
      cand = {1'b0, head.addr[39:7], idx[0], head.addr[6:0]};
    end
  end

  always_comb begin
    out_item_nxt             = '0;
    out_item_nxt.result_kind = head.mode;
    out_item_nxt.type_out    = head.access_type;
    out_item_nxt.length_out  = head.access_length;
    out_item_nxt.last        = is_last;
    case (head.mode)
      KIND_RAW: begin
        out_item_nxt.candidate_address = {2'b00, head.addr};
      end
      KIND_POSSIBLE: begin
        out_item_nxt.candidate_address = cand;
        out_item_nxt.candidate_index   = idx;
      end
      KIND_MATCHED: begin
        out_item_nxt.candidate_address = cand;
        out_item_nxt.candidate_index   = idx;
        out_item_nxt.hash_channel      = head.hash;
      end
      default: begin
        out_item_nxt.candidate_address = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!empty) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* sv/ddr_channel_address_untranslate.sv */
// Top level of the DDR channel address untranslate block.
// Depends on dcau_pkg, dcau_front, dcau_queue and dcau_back.
//
//   port group   direction  handshake                 payload
//   in_          input      start && !busy            in_item (in_item_t)
//   out_         output     out_valid, one cycle      out_item (out_item_t)
//   cfg_         input      cfg_we                    cfg_index, cfg_wdata
//
// The back end emits one result per cycle: a transaction gives one result in raw,
// matched or no-match mode, two or four when all candidates go out.
// Each accepted job is stored in the job queue, and its results leave through
// the registered result port.
// busy rises while the four-entry job queue is full.
// Synchronous active-low reset empties the queue and sets the layout to
// untranslated and the channel id to unknown. Results cannot be stalled.
module ddr_channel_address_untranslate import dcau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_valid,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  job_t push_job;
  job_t head;

  dcau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .start    (start),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  dcau_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .empty   (q_empty),
    .full    (q_full),
    .head    (head)
  );

  dcau_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (q_empty),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  assign busy = q_full;

endmodule
